/* sv/tsb_pkg.sv */
// Shared types and constants of the bilinear texture sampler.
// No dependencies; imported by the sampler, its texel bank and its checker.
`default_nettype none
package tsb_pkg;

    // Fixed field widths
    localparam int DIM_W     = 9;   // width/height register
    localparam int COORD_W   = 32;  // signed Q16.16 coordinate
    localparam int TEXEL_W   = 32;  // RGBA8 texel
    localparam int INDEX_W   = 16;  // row-major write index
    localparam int CH_W      = 16;  // Q8.8 output channel
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes of the configuration port
    localparam t_cfg_idx CFG_TEX_WIDTH   = 3'd0;
    localparam t_cfg_idx CFG_TEX_HEIGHT  = 3'd1;
    localparam t_cfg_idx CFG_WRAP_S      = 3'd2;
    localparam t_cfg_idx CFG_WRAP_T      = 3'd3;
    localparam t_cfg_idx CFG_FILTER_MODE = 3'd4;

    // Item kinds carried on tuser
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Largest channel value; also the alpha of the default color
    localparam logic [CH_W-1:0] CH_MAX = 16'hFF00;

endpackage
`default_nettype wire

/* sv/tsb_bank.sv */
// One copy of the texel store: one write port, one registered read port.
// Uses tsb_pkg for the texel width.
`default_nettype none
module tsb_bank
    import tsb_pkg::*;
#(
    parameter int DEPTH = 65536
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [TEXEL_W-1:0]        i_wdata,
    input  wire                       i_re,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [TEXEL_W-1:0]        o_rdata
);

    logic [TEXEL_W-1:0] r_mem [DEPTH];

    // Store one texel
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read and hold while the next stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/texture_sampler_bilinear.sv */
// Bilinear RGBA8 texture sampler, top level.
// Depends on tsb_pkg and four tsb_bank texel store copies.
//
// Usage:
//   Configuration: write tex_width (0), tex_height (1), wrap_mode_s (2),
//   wrap_mode_t (3) and filter_mode (4) on the i_cfg_* channel while no item
//   is in flight. o_cfg_ready is always high; indexes above 4 are dropped.
//   Input stream: tuser selects a texel write (0) or a sample (1). A write
//   stores tdata[47:16] at tdata[15:0]; a sample uses u and v (Q16.16).
//   Output stream: one RGBA result per sample, Q8.8 channels; writes give
//   no result. Zero width or height gives (0,0,0,255.0).
//   Pipeline: a sample passes through twelve registered stages to the output.
//   Throughput: one item per cycle unless the output stalls, through the
//   twelve-stage pipeline; the four texel reads of a bilinear footprint come
//   from four replicated store copies, each with its own read port, in the same cycle.
//   A write reaches the store as it leaves stage 8, in order with
//   samples, so a later sample always sees it.
//   Reset clears all stage valids and the configuration registers; the texel store
//   contents are undefined until written.
//   Stall: each stage holds its item while the stage after it is full and
//   cannot advance; bubbles collapse, and s_axis_tready falls only when every stage is full.
`default_nettype none
module texture_sampler_bilinear
    import tsb_pkg::*;
#(
    parameter int MAX_DIM     = 256,
    parameter int TEXEL_DEPTH = 65536,
    parameter int WEIGHT_BITS = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // Configuration write channel
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire  [CFG_DAT_W-1:0]  i_cfg_data,
    // Input stream
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: texel_index[15:0], texel_word[47:16], coord_u[79:48], coord_v[111:80]
    input  wire  [111:0]          s_axis_tdata,
    // tuser: kind[0]
    input  wire  [0:0]            s_axis_tuser,
    // Output stream
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // tdata: red[15:0], green[31:16], blue[47:32], alpha[63:48]
    output logic [63:0]           m_axis_tdata
);

    localparam int NS     = 12;                 // pipeline stages
    localparam int ST_MEM = 9;                  // stage holding store read data
    localparam int AW     = $clog2(TEXEL_DEPTH);
    localparam int UW     = 17;                 // wrapped coordinate, 0..65536
    localparam int GW     = UW + DIM_W;         // scaled position
    localparam int AXW    = GW - 16;            // integer part of position
    localparam int LW     = 2 * DIM_W;          // linear texel index
    localparam int QW     = LW - 1;             // quotient estimate
    localparam int PW     = LW + QW;
    localparam int TW     = 8 + WEIGHT_BITS;    // row blend
    localparam int ACW    = 8 + 2 * WEIGHT_BITS;// column blend
    localparam int SH     = 2 * WEIGHT_BITS - 8;
    localparam int HALF_RND = (1 << SH) >> 1;
    localparam logic [QW-1:0] RECIP_C = QW'((1 << LW) / TEXEL_DEPTH);
    localparam logic [WEIGHT_BITS:0] W_ONE = (WEIGHT_BITS+1)'(1 << WEIGHT_BITS);
    localparam logic [GW-1:0] HALF_TEXEL = GW'(32768);
    localparam logic [UW-1:0] ONE_Q16 = UW'(65536);

    // ---------------- configuration ----------------
    logic [DIM_W-1:0] r_tex_width, r_tex_height;
    logic             r_wrap_s, r_wrap_t, r_filter;

    assign o_cfg_ready = 1'b1;

    // Take one register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= '0;
            r_tex_height <= '0;
            r_wrap_s     <= 1'b0;
            r_wrap_t     <= 1'b0;
            r_filter     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TEX_WIDTH:   r_tex_width  <= i_cfg_data;
                CFG_TEX_HEIGHT:  r_tex_height <= i_cfg_data;
                CFG_WRAP_S:      r_wrap_s     <= i_cfg_data[0];
                CFG_WRAP_T:      r_wrap_t     <= i_cfg_data[0];
                CFG_FILTER_MODE: r_filter     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Size in use, limited to MAX_DIM
    logic [DIM_W-1:0] w_c, h_c, wm1, hm1;
    always_comb begin
        w_c = (32'(r_tex_width)  > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_tex_width;
        h_c = (32'(r_tex_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_tex_height;
        wm1 = w_c - DIM_W'(1);
        hm1 = h_c - DIM_W'(1);
    end

    // ---------------- pipeline flow control ----------------
    logic [NS:1] r_vld, rdy, vin;
    logic        r8_kind;

    always_comb begin
        rdy[NS] = !r_vld[NS] || m_axis_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        vin[1] = s_axis_tvalid;
        for (int k = 2; k <= NS; k++) begin
            vin[k] = r_vld[k-1];
        end
        // Writes leave the pipeline once they reach the store
        vin[ST_MEM] = r_vld[ST_MEM-1] && (r8_kind == KIND_SAMPLE);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= vin[k];
                end
            end
        end
    end

    assign s_axis_tready = rdy[1];

    // Clamp a texel coordinate against size-1
    function automatic logic [DIM_W-1:0] clamp_top(input logic [AXW-1:0] a,
                                                   input logic [DIM_W-1:0] lim);
        logic [AXW-1:0] l;
        l = AXW'(lim);
        return (a > l) ? lim : a[DIM_W-1:0];
    endfunction

    // Wrap one coordinate to 0..65536
    function automatic logic [UW-1:0] wrap_q16(input logic [COORD_W-1:0] c,
                                               input logic rep);
        logic [UW-1:0] r;
        if (rep) begin
            r = {1'b0, c[15:0]};
        end else if (c[COORD_W-1]) begin
            r = '0;
        end else if (c > COORD_W'(ONE_Q16)) begin
            r = ONE_Q16;
        end else begin
            r = c[UW-1:0];
        end
        return r;
    endfunction

    // ---------------- stage 1: capture and wrap ----------------
    logic                r1_kind, r1_wok;
    logic [INDEX_W-1:0]  r1_idx;
    logic [TEXEL_W-1:0]  r1_word;
    logic [UW-1:0]       r1_us, r1_vs;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_kind <= s_axis_tuser[0];
            r1_idx  <= s_axis_tdata[15:0];
            r1_wok  <= 32'(s_axis_tdata[15:0]) < 32'(TEXEL_DEPTH);
            r1_word <= s_axis_tdata[47:16];
            r1_us   <= wrap_q16(s_axis_tdata[79:48], r_wrap_s);
            r1_vs   <= wrap_q16(s_axis_tdata[111:80], r_wrap_t);
        end
    end

    // ---------------- stage 2: scale by size ----------------
    logic [GW-1:0]       n2_gx, n2_gy, r2_gx, r2_gy;
    logic                r2_kind, r2_wok;
    logic [INDEX_W-1:0]  r2_idx;
    logic [TEXEL_W-1:0]  r2_word;

    always_comb begin
        logic [GW-1:0] pu, pv, wu, wv;
        pu = GW'(r1_us);
        pv = GW'(r1_vs);
        wu = GW'(w_c);
        wv = GW'(h_c);
        n2_gx = pu * wu + (r_filter ? HALF_TEXEL : '0);
        n2_gy = pv * wv + (r_filter ? HALF_TEXEL : '0);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_gx   <= n2_gx;
            r2_gy   <= n2_gy;
            r2_kind <= r1_kind;
            r2_wok  <= r1_wok;
            r2_idx  <= r1_idx;
            r2_word <= r1_word;
        end
    end

    // ---------------- stage 3: texel coordinates and weights ----------------
    logic [DIM_W-1:0]       n3_x0, n3_x1, n3_y0, n3_y1;
    logic [DIM_W-1:0]       r3_x0, r3_x1, r3_y0, r3_y1;
    logic [WEIGHT_BITS-1:0] r3_wx, r3_wy;
    logic                   r3_kind, r3_wok;
    logic [INDEX_W-1:0]     r3_idx;
    logic [TEXEL_W-1:0]     r3_word;

    always_comb begin
        logic [AXW-1:0] ax, ay;
        ax = r2_gx[GW-1:16];
        ay = r2_gy[GW-1:16];
        n3_x1 = clamp_top(ax, wm1);
        n3_y1 = clamp_top(ay, hm1);
        n3_x0 = n3_x1;
        n3_y0 = n3_y1;
        if (r_filter) begin
            n3_x0 = (ax == '0) ? '0 : clamp_top(ax - AXW'(1), wm1);
            n3_y0 = (ay == '0) ? '0 : clamp_top(ay - AXW'(1), hm1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_x0   <= n3_x0;
            r3_x1   <= n3_x1;
            r3_y0   <= n3_y0;
            r3_y1   <= n3_y1;
            r3_wx   <= r2_gx[15 -: WEIGHT_BITS];
            r3_wy   <= r2_gy[15 -: WEIGHT_BITS];
            r3_kind <= r2_kind;
            r3_wok  <= r2_wok;
            r3_idx  <= r2_idx;
            r3_word <= r2_word;
        end
    end

    // ---------------- stage 4: row offsets ----------------
    logic [LW-1:0]          r4_row0, r4_row1;
    logic [DIM_W-1:0]       r4_x0, r4_x1;
    logic [WEIGHT_BITS-1:0] r4_wx, r4_wy;
    logic                   r4_kind, r4_wok;
    logic [INDEX_W-1:0]     r4_idx;
    logic [TEXEL_W-1:0]     r4_word;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_row0 <= LW'(r3_y0) * LW'(w_c);
            r4_row1 <= LW'(r3_y1) * LW'(w_c);
            r4_x0   <= r3_x0;
            r4_x1   <= r3_x1;
            r4_wx   <= r3_wx;
            r4_wy   <= r3_wy;
            r4_kind <= r3_kind;
            r4_wok  <= r3_wok;
            r4_idx  <= r3_idx;
            r4_word <= r3_word;
        end
    end

    // ---------------- stage 5: linear indexes of the footprint ----------------
    // Lane order: (x0,y0), (x1,y0), (x0,y1), (x1,y1)
    logic [LW-1:0]          r5_lin [4];
    logic [WEIGHT_BITS-1:0] r5_wx, r5_wy;
    logic                   r5_kind, r5_wok;
    logic [INDEX_W-1:0]     r5_idx;
    logic [TEXEL_W-1:0]     r5_word;

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r5_lin[0] <= r4_row0 + LW'(r4_x0);
            r5_lin[1] <= r4_row0 + LW'(r4_x1);
            r5_lin[2] <= r4_row1 + LW'(r4_x0);
            r5_lin[3] <= r4_row1 + LW'(r4_x1);
            r5_wx     <= r4_wx;
            r5_wy     <= r4_wy;
            r5_kind   <= r4_kind;
            r5_wok    <= r4_wok;
            r5_idx    <= r4_idx;
            r5_word   <= r4_word;
        end
    end

    // ---------------- stage 6: quotient estimate by reciprocal ----------------
    logic [QW-1:0]          r6_q   [4];
    logic [LW-1:0]          r6_lin [4];
    logic [WEIGHT_BITS-1:0] r6_wx, r6_wy;
    logic                   r6_kind, r6_wok;
    logic [INDEX_W-1:0]     r6_idx;
    logic [TEXEL_W-1:0]     r6_word;

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            for (int j = 0; j < 4; j++) begin
                logic [PW-1:0] prod;
                prod      = PW'(r5_lin[j]) * PW'(RECIP_C);
                r6_q[j]   <= prod[PW-1:LW];
                r6_lin[j] <= r5_lin[j];
            end
            r6_wx   <= r5_wx;
            r6_wy   <= r5_wy;
            r6_kind <= r5_kind;
            r6_wok  <= r5_wok;
            r6_idx  <= r5_idx;
            r6_word <= r5_word;
        end
    end

    // ---------------- stage 7: remainder, off by at most one depth ----------------
    logic [LW-1:0]          r7_rem [4];
    logic [WEIGHT_BITS-1:0] r7_wx, r7_wy;
    logic                   r7_kind, r7_wok;
    logic [INDEX_W-1:0]     r7_idx;
    logic [TEXEL_W-1:0]     r7_word;

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            for (int j = 0; j < 4; j++) begin
                r7_rem[j] <= r6_lin[j] - LW'(64'(r6_q[j]) * 64'(TEXEL_DEPTH));
            end
            r7_wx   <= r6_wx;
            r7_wy   <= r6_wy;
            r7_kind <= r6_kind;
            r7_wok  <= r6_wok;
            r7_idx  <= r6_idx;
            r7_word <= r6_word;
        end
    end

    // ---------------- stage 8: store addresses ----------------
    logic [AW-1:0]          r8_addr [4];
    logic [WEIGHT_BITS-1:0] r8_wx, r8_wy;
    logic                   r8_wok;
    logic [INDEX_W-1:0]     r8_idx;
    logic [TEXEL_W-1:0]     r8_word;

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            for (int j = 0; j < 4; j++) begin
                if (32'(r7_rem[j]) >= 32'(TEXEL_DEPTH)) begin
                    r8_addr[j] <= AW'(32'(r7_rem[j]) - 32'(TEXEL_DEPTH));
                end else begin
                    r8_addr[j] <= AW'(r7_rem[j]);
                end
            end
            r8_wx   <= r7_wx;
            r8_wy   <= r7_wy;
            r8_kind <= r7_kind;
            r8_wok  <= r7_wok;
            r8_idx  <= r7_idx;
            r8_word <= r7_word;
        end
    end

    // ---------------- stage 9: texel store, one copy per footprint lane ----------------
    logic                   st_we;
    logic [TEXEL_W-1:0]     rd_texel [4];
    logic [WEIGHT_BITS-1:0] r9_wx, r9_wy;

    assign st_we = r_vld[ST_MEM-1] && (r8_kind == KIND_WRITE) && r8_wok && rdy[ST_MEM];

    for (genvar j = 0; j < 4; j++) begin : g_bank
        tsb_bank #(
            .DEPTH (TEXEL_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (st_we),
            .i_waddr (AW'(r8_idx)),
            .i_wdata (r8_word),
            .i_re    (rdy[ST_MEM]),
            .i_raddr (r8_addr[j]),
            .o_rdata (rd_texel[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_MEM]) begin
            r9_wx <= r8_wx;
            r9_wy <= r8_wy;
        end
    end

    // ---------------- stage 10: horizontal blend ----------------
    logic [TW-1:0]          r10_top [4], r10_bot [4];
    logic [7:0]             r10_near [4];
    logic [WEIGHT_BITS-1:0] r10_wy;

    always_ff @(posedge i_clk) begin
        if (rdy[10]) begin
            for (int c = 0; c < 4; c++) begin
                logic [TW-1:0] a0, a1, a2, a3, wl, wr;
                a0 = TW'(rd_texel[0][8*c +: 8]);
                a1 = TW'(rd_texel[1][8*c +: 8]);
                a2 = TW'(rd_texel[2][8*c +: 8]);
                a3 = TW'(rd_texel[3][8*c +: 8]);
                wl = TW'(W_ONE - (WEIGHT_BITS+1)'(r9_wx));
                wr = TW'(r9_wx);
                r10_top[c]  <= a0 * wl + a1 * wr;
                r10_bot[c]  <= a2 * wl + a3 * wr;
                r10_near[c] <= rd_texel[0][8*c +: 8];
            end
            r10_wy <= r9_wy;
        end
    end

    // ---------------- stage 11: vertical blend ----------------
    logic [ACW-1:0] r11_acc [4];
    logic [7:0]     r11_near [4];

    always_ff @(posedge i_clk) begin
        if (rdy[11]) begin
            for (int c = 0; c < 4; c++) begin
                logic [ACW-1:0] t, b, wt, wb;
                t  = ACW'(r10_top[c]);
                b  = ACW'(r10_bot[c]);
                wt = ACW'(W_ONE - (WEIGHT_BITS+1)'(r10_wy));
                wb = ACW'(r10_wy);
                r11_acc[c]  <= t * wt + b * wb;
                r11_near[c] <= r10_near[c];
            end
        end
    end

    // ---------------- stage 12: round, select, output register ----------------
    logic [CH_W-1:0] r12_ch [4];

    always_ff @(posedge i_clk) begin
        if (rdy[NS]) begin
            for (int c = 0; c < 4; c++) begin
                logic [ACW:0] rnd;
                rnd = (ACW+1)'(r11_acc[c]) + (ACW+1)'(HALF_RND);
                rnd = rnd >> SH;
                if (w_c == '0 || h_c == '0) begin
                    r12_ch[c] <= (c == 3) ? CH_MAX : '0;
                end else if (r_filter) begin
                    r12_ch[c] <= rnd[CH_W-1:0];
                end else begin
                    r12_ch[c] <= {r11_near[c], 8'h00};
                end
            end
        end
    end

    assign m_axis_tvalid = r_vld[NS];
    assign m_axis_tdata  = {r12_ch[3], r12_ch[2], r12_ch[1], r12_ch[0]};

endmodule
`default_nettype wire

/* sv/tsb_checker.sv */
// Port-level checks of the texture sampler, bound to its top level.
// Depends on tsb_pkg for the channel limit.
`default_nettype none
module tsb_checker
    import tsb_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_cfg_ready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [63:0] m_axis_tdata
);

    // Register port never pushes back once out of reset
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown after reset");

    // Every channel stays on the 0..255 scale
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= CH_MAX) && (m_axis_tdata[31:16] <= CH_MAX)
                       && (m_axis_tdata[47:32] <= CH_MAX) && (m_axis_tdata[63:48] <= CH_MAX))
        else $error("channel above full scale");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind texture_sampler_bilinear tsb_checker u_tsb_checker (.*);
`default_nettype wire

/* verif/tb_texture_sampler_bilinear.sv */
// Self-checking bench for texture_sampler_bilinear: random texel writes and
// samples under varied wrap, filter and size settings, with idling phases.
// Depends on tsb_pkg and the sampler RTL.
`timescale 1ns / 1ps
module tb_texture_sampler_bilinear;
    import tsb_pkg::*;

    localparam int MAX_DIM_TB = 256;
    localparam int DEPTH = 65536;
    localparam int SETTLE = 40;

    typedef struct packed {
        logic        kind;
        logic [31:0] coord_v;
        logic [31:0] coord_u;
        logic [31:0] texel_word;
        logic [15:0] texel_index;
    } t_item;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } t_rgba;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    // Transfer flag captured at the rising edge for the driver
    logic s_axis_tready_q = 0;

    texture_sampler_bilinear u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow texture and registers
    logic [31:0] shadow_texels [DEPTH];
    logic [8:0]  cur_width, cur_height;
    logic        cur_wrap_s, cur_wrap_t, cur_bilinear;

    t_item pending_items[$];
    t_rgba expected_colors[$];
    int    mismatches = 0;
    int    samples_checked = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    recv_hold = 0;
    // texel range [0, written_limit) is known to be written
    int    written_limit = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic longint fold_coord(input logic [31:0] raw, input logic repeat_on);
        longint c;
        c = longint'($signed(raw));
        if (repeat_on) return longint'(raw[15:0]);
        if (c < 0) return 0;
        if (c > 65536) return 65536;
        return c;
    endfunction

    function automatic logic [31:0] fetch_texel(input longint x, input longint y,
                                                input longint w, input longint h);
        longint cx, cy;
        cx = x < 0 ? 0 : (x > w - 1 ? w - 1 : x);
        cy = y < 0 ? 0 : (y > h - 1 ? h - 1 : y);
        return shadow_texels[(cy * w + cx) % DEPTH];
    endfunction

    // Update the shadow store or compute the color a sample must return
    function automatic bit predict_color(input t_item it, output t_rgba col);
        longint w, h, us, vs, fx, fy, x0, y0, wx, wy, top, bot, acc;
        logic [31:0] t00, t10, t01, t11;
        logic [15:0] ch [4];
        col = '0;
        if (it.kind == KIND_WRITE) begin
            shadow_texels[it.texel_index] = it.texel_word;
            return 0;
        end
        w = cur_width > MAX_DIM_TB ? MAX_DIM_TB : cur_width;
        h = cur_height > MAX_DIM_TB ? MAX_DIM_TB : cur_height;
        if (w == 0 || h == 0) begin
            col.alpha = CH_MAX;
            return 1;
        end
        us = fold_coord(it.coord_u, cur_wrap_s);
        vs = fold_coord(it.coord_v, cur_wrap_t);
        if (!cur_bilinear) begin
            t00 = fetch_texel((us * w) >>> 16, (vs * h) >>> 16, w, h);
            for (int k = 0; k < 4; k++) ch[k] = {t00[8*k +: 8], 8'h00};
        end else begin
            fx = us * w + 32768;
            fy = vs * h + 32768;
            x0 = (fx >>> 16) - 1;
            y0 = (fy >>> 16) - 1;
            wx = (fx & 65535) >> 8;
            wy = (fy & 65535) >> 8;
            t00 = fetch_texel(x0, y0, w, h);
            t10 = fetch_texel(x0 + 1, y0, w, h);
            t01 = fetch_texel(x0, y0 + 1, w, h);
            t11 = fetch_texel(x0 + 1, y0 + 1, w, h);
            for (int k = 0; k < 4; k++) begin
                top = t00[8*k +: 8] * (256 - wx) + t10[8*k +: 8] * wx;
                bot = t01[8*k +: 8] * (256 - wx) + t11[8*k +: 8] * wx;
                acc = top * (256 - wy) + bot * wy;
                ch[k] = 16'((acc + 128) >> 8);
            end
        end
        col = {ch[3], ch[2], ch[1], ch[0]};
        return 1;
    endfunction

    // Driver: offer queued items, change inputs on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready_q) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_item it;
                    it = pending_items.pop_front();
                    s_axis_tdata <= {it.coord_v, it.coord_u, it.texel_word, it.texel_index};
                    s_axis_tuser <= it.kind;
                    s_axis_tvalid <= 1;
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Record each input transfer and predict its result
    always @(posedge i_clk) begin
        t_rgba col;
        t_item it;
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            it = {s_axis_tuser[0], s_axis_tdata[111:80], s_axis_tdata[79:48],
                  s_axis_tdata[47:16], s_axis_tdata[15:0]};
            if (predict_color(it, col)) expected_colors.push_back(col);
        end
    end

    // Monitor: compare each result with the oldest expected color
    always @(posedge i_clk) begin
        t_rgba got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_colors.size() == 0) begin
                report_mismatch("result with none expected, red", got.red, 16'h0000);
            end else begin
                want = expected_colors.pop_front();
                samples_checked++;
                if (got.red != want.red) report_mismatch("red", got.red, want.red);
                if (got.green != want.green) report_mismatch("green", got.green, want.green);
                if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
                if (got.alpha != want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_colors.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        @(negedge i_clk);
        i_cfg_addr <= idx;
        i_cfg_data <= CFG_DAT_W'(val);
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TEX_WIDTH:   cur_width = 9'(val);
            CFG_TEX_HEIGHT:  cur_height = 9'(val);
            CFG_WRAP_S:      cur_wrap_s = val[0];
            CFG_WRAP_T:      cur_wrap_t = val[0];
            CFG_FILTER_MODE: cur_bilinear = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic configure(input int w, input int h, input int ws, input int wt,
                             input int fm);
        write_reg(CFG_TEX_WIDTH, w);
        write_reg(CFG_TEX_HEIGHT, h);
        write_reg(CFG_WRAP_S, ws);
        write_reg(CFG_WRAP_T, wt);
        write_reg(CFG_FILTER_MODE, fm);
    endtask

    task automatic queue_write(input int idx, input logic [31:0] word);
        t_item it;
        it = '0;
        it.kind = KIND_WRITE;
        it.texel_index = 16'(idx);
        it.texel_word = word;
        it.coord_u = $urandom();
        it.coord_v = $urandom();
        pending_items.push_back(it);
    endtask

    task automatic queue_sample(input logic [31:0] u, input logic [31:0] v);
        t_item it;
        it = '0;
        it.kind = KIND_SAMPLE;
        it.coord_u = u;
        it.coord_v = v;
        it.texel_index = $urandom();
        it.texel_word = $urandom();
        pending_items.push_back(it);
    endtask

    // Random coordinate: mostly near [0,1], sometimes anywhere
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(196608)) - 65536);
            default: return $urandom_range(65536);
        endcase
    endfunction

    // Make sure the footprint of a w x h texture is written
    task automatic fill_texture(input int w, input int h);
        for (int i = written_limit; i < w * h; i++) shadow_texels[i] = 0;
        while (written_limit < w * h) begin
            queue_write(written_limit, $urandom());
            written_limit++;
        end
    endtask

    initial begin
        int w, h, n_rand;
        cur_width = 0; cur_height = 0;
        cur_wrap_s = 0; cur_wrap_t = 0; cur_bilinear = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Zero size gives the default color; no texels read
        queue_sample(32'h0000_8000, 32'h0000_8000);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();
        configure(4, 0, 1, 1, 1);
        queue_sample(32'hFFFF_FFFF, 32'h0001_0000);
        wait_drained();

        // Directed 2x2: extremes of coordinates, both filters, clamp and repeat
        configure(2, 2, 0, 0, 0);
        queue_write(0, 32'hFFFF_FFFF);
        queue_write(1, 32'h0000_0000);
        queue_write(2, 32'hA5A5_5A5A);
        queue_write(3, 32'h0123_4567);
        written_limit = 4;
        queue_write(65535, 32'hDEAD_BEEF); // top of store, harmless
        queue_sample(32'h0000_0000, 32'h0000_0000);
        queue_sample(32'h0001_0000, 32'h0001_0000);
        queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
        queue_sample(32'h0000_7FFF, 32'h0000_C000);
        wait_drained();
        configure(2, 2, 1, 1, 1);
        queue_sample(32'h0000_8000, 32'h0000_8000);
        queue_sample(32'hFFFF_FFFF, 32'h8000_0000);
        queue_sample(32'h0000_4000, 32'h0001_C000);
        wait_drained();
        configure(2, 2, 0, 0, 1);
        queue_sample(32'h0000_0000, 32'h0001_0000);
        queue_sample(32'hFFFF_0000, 32'h0000_4321);
        wait_drained();

        // Random phases through several settings and idling patterns
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            case (phase)
                0: begin w = 1;   h = 1;   end
                1: begin w = 256; h = 1;   end
                2: begin w = 1;   h = 256; end
                3: begin w = 511; h = 1;   end   // oversized width
                default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
            endcase
            configure(w, h, $urandom_range(1), $urandom_range(1), $urandom_range(1));
            w = w > MAX_DIM_TB ? MAX_DIM_TB : w;
            fill_texture(w, h);
            n_rand = 22;
            for (int i = 0; i < n_rand; i++) begin
                if ($urandom_range(4) == 0) queue_write($urandom_range(w * h - 1), $urandom());
                else queue_sample(rand_coord(), rand_coord());
            end
            if (phase == 5) begin
                // Long receiver hold-off while items keep coming
                recv_hold = 1;
                repeat (200) @(posedge i_clk);
                recv_hold = 0;
            end
            wait_drained();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        $display("Run covered %0d checked samples over clamp/repeat, nearest/bilinear,",
                 samples_checked);
        $display("zero, unit, oversized and random texture sizes with stall phases.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
